/* hdl/maap_pkg.sv */
// Shared types and constants of the motion-aware alpha pixel kernel.
// Used by every module of the block; depends on nothing else.
package maap_pkg;

    // Quotient bits produced by the pipelined dividers (one per stage).
    localparam int QBITS = 21;

    // Datapath widths.
    localparam int SQ_W   = 31;             // one square of a signed 16-bit value
    localparam int MAG_W  = 32;             // sum of two squares
    localparam int DEN_W  = 33;             // sum of two magnitudes
    localparam int RR_W   = MAG_W + 16;     // ratio dividend, magnitude times 2^16
    localparam int DSH_W  = DEN_W + QBITS - 1;
    localparam int MDIV_W = 16;
    localparam int MSH_W  = MDIV_W + QBITS - 1;
    localparam int PROD_W = 16 + QBITS;     // weight times motion term
    localparam int ACC_W  = PROD_W + 2;

    // Region codes.
    localparam logic [1:0] REGION_BG      = 2'd0;
    localparam logic [1:0] REGION_UNKNOWN = 2'd1;
    localparam logic [1:0] REGION_FG      = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SRC_WEIGHT = 2'd0;
    localparam logic [1:0] CFG_TGT_WEIGHT = 2'd1;
    localparam logic [1:0] CFG_MOTION_DIV = 2'd2;

    // Fixed-point constants.
    localparam logic [16:0]      ONE_Q16  = 17'd65536;
    localparam logic [16:0]      HALF_Q16 = 17'd32768;
    localparam logic [QBITS-1:0] D_SAT    = QBITS'(1048576);
    localparam logic [ACC_W-1:0] ONE_Q24  = ACC_W'(16777216);

    // One input pixel as it arrives.
    typedef struct packed {
        logic               outer_mask;
        logic               inner_mask;
        logic signed [15:0] src_grad_x;
        logic signed [15:0] src_grad_y;
        logic signed [15:0] tgt_grad_x;
        logic signed [15:0] tgt_grad_y;
        logic        [16:0] src_conf;
        logic signed [15:0] src_flow_x;
        logic signed [15:0] src_flow_y;
        logic        [16:0] tgt_conf;
        logic signed [15:0] tgt_flow_x;
        logic signed [15:0] tgt_flow_y;
    } t_pix;

    // After the squaring stage.
    typedef struct packed {
        logic [1:0]      region;
        logic [SQ_W-1:0] sq_sgx;
        logic [SQ_W-1:0] sq_sgy;
        logic [SQ_W-1:0] sq_tgx;
        logic [SQ_W-1:0] sq_tgy;
        logic [SQ_W-1:0] sq_sfx;
        logic [SQ_W-1:0] sq_sfy;
        logic [SQ_W-1:0] sq_tfx;
        logic [SQ_W-1:0] sq_tfy;
        logic [16:0]     src_conf;
        logic [16:0]     tgt_conf;
    } t_sq;

    // After the magnitude sums.
    typedef struct packed {
        logic [1:0]       region;
        logic [MAG_W-1:0] gs;
        logic [DEN_W-1:0] den;
        logic [MAG_W-1:0] src_mag;
        logic [MAG_W-1:0] tgt_mag;
        logic             src_hi;
        logic             tgt_hi;
        logic [16:0]      src_low;
        logic [16:0]      tgt_low;
    } t_mag;

    // State of the three restoring dividers, one quotient bit per stage.
    typedef struct packed {
        logic [1:0]       region;
        logic             den_zero;
        logic [DSH_W-1:0] den_sh;
        logic [RR_W-1:0]  rat_rem;
        logic [QBITS-1:0] rat_q;
        logic [MSH_W-1:0] mdiv_sh;
        logic             src_hi;
        logic             src_sat;
        logic [16:0]      src_low;
        logic [MAG_W-1:0] src_rem;
        logic [QBITS-1:0] src_q;
        logic             tgt_hi;
        logic             tgt_sat;
        logic [16:0]      tgt_low;
        logic [MAG_W-1:0] tgt_rem;
        logic [QBITS-1:0] tgt_q;
    } t_div;

    // Weighted motion terms and the gradient ratio.
    typedef struct packed {
        logic [1:0]        region;
        logic [16:0]       ratio;
        logic [PROD_W-1:0] src_prod;
        logic [PROD_W-1:0] tgt_prod;
    } t_prod;

endpackage

/* hdl/motion_aware_alpha_pixel.sv */
// Motion-aware per-pixel blend weight: 26 register stages, one pixel per clock unless stalled.
// A result passes 3 front stages, 21 divider stages of one quotient bit each and 2 blend
// stages before it reaches the output register.
// Each stage holds on its own while the next is blocked, so bubbles close up.
// Reset (synchronous, active low) empties the pipeline and loads the weights with 256
// and the motion divisor with 50.
module motion_aware_alpha_pixel (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    // Pixel input.
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata, from bit 0: src_grad_x[15:0], src_grad_y[31:16], tgt_grad_x[47:32],
    // tgt_grad_y[63:48], src_conf[80:64], src_flow_x[96:81], src_flow_y[112:97],
    // tgt_conf[129:113], tgt_flow_x[145:130], tgt_flow_y[161:146], zeros to 167.
    input  logic [167:0] s_axis_tdata,
    // tuser, from bit 0: outer_mask[0], inner_mask[1].
    input  logic [1:0]   s_axis_tuser,
    // Result output.
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata, from bit 0: alpha[16:0], zeros to 23.
    output logic [23:0]  m_axis_tdata,
    // tuser, from bit 0: region[1:0].
    output logic [1:0]   m_axis_tuser
);
    import maap_pkg::*;

    logic [15:0] r_src_weight;
    logic [15:0] r_tgt_weight;
    logic [15:0] r_motion_div;

    t_pix        w_pix;
    t_div        w_div [0:QBITS];
    logic        w_v   [0:QBITS];
    logic        w_rdy [0:QBITS];
    logic [16:0] w_alpha;
    logic [1:0]  w_region;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_weight <= 16'd256;
            r_tgt_weight <= 16'd256;
            r_motion_div <= 16'd50;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SRC_WEIGHT: r_src_weight <= i_cfg_data;
                CFG_TGT_WEIGHT: r_tgt_weight <= i_cfg_data;
                CFG_MOTION_DIV: r_motion_div <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Unpack the input request.
    always_comb begin
        w_pix.outer_mask = s_axis_tuser[0];
        w_pix.inner_mask = s_axis_tuser[1];
        w_pix.src_grad_x = s_axis_tdata[15:0];
        w_pix.src_grad_y = s_axis_tdata[31:16];
        w_pix.tgt_grad_x = s_axis_tdata[47:32];
        w_pix.tgt_grad_y = s_axis_tdata[63:48];
        w_pix.src_conf   = s_axis_tdata[80:64];
        w_pix.src_flow_x = s_axis_tdata[96:81];
        w_pix.src_flow_y = s_axis_tdata[112:97];
        w_pix.tgt_conf   = s_axis_tdata[129:113];
        w_pix.tgt_flow_x = s_axis_tdata[145:130];
        w_pix.tgt_flow_y = s_axis_tdata[161:146];
    end

    // Squares, sums and divider setup.
    maap_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_pix        (w_pix),
        .i_motion_div (r_motion_div),
        .o_valid      (w_v[0]),
        .i_ready      (w_rdy[0]),
        .o_div        (w_div[0])
    );

    // Divider pipeline, one quotient bit per stage, most significant first.
    for (genvar k = 0; k < QBITS; k++) begin : g_step
        maap_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_div   (w_div[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    // Weighting, clamp and output register.
    maap_blend u_blend (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_v[QBITS]),
        .o_ready      (w_rdy[QBITS]),
        .i_div        (w_div[QBITS]),
        .i_src_weight (r_src_weight),
        .i_tgt_weight (r_tgt_weight),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_alpha      (w_alpha),
        .o_region     (w_region)
    );

    assign m_axis_tdata = {7'd0, w_alpha};
    assign m_axis_tuser = w_region;

    // The pipeline only refuses a request when the output is blocked.
    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled while the output was free");

    // Alpha never exceeds one.
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_alpha <= ONE_Q16))
        else $error("alpha above one");

    // Background gives zero and foreground gives one.
    a_trimap_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((w_region != REGION_BG || w_alpha == 17'd0) &&
                           (w_region != REGION_FG || w_alpha == ONE_Q16)))
        else $error("trimap override broken");

    // A result that waits is not replaced.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(w_alpha)))
        else $error("stalled result changed");

endmodule

/* hdl/maap_front.sv */
// Front end of the kernel: squares, magnitude sums and divider setup, three stages.
// Depends on maap_pkg.
module maap_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  maap_pkg::t_pix      i_pix,
    input  logic [15:0]         i_motion_div,
    output logic                o_valid,
    input  logic                i_ready,
    output maap_pkg::t_div      o_div
);
    import maap_pkg::*;

    logic r_v1, r_v2, r_v3;
    logic w_adv1, w_adv2, w_adv3;
    t_sq  r_sq,  n_sq;
    t_mag r_mag, n_mag;
    t_div r_div, n_div;
    logic [MDIV_W-1:0] w_div;

    function automatic logic [SQ_W-1:0] sq16(input logic signed [15:0] a);
        logic signed [31:0] p;
        p = a * a;
        return p[SQ_W-1:0];
    endfunction

    // A stage moves on when it is empty or the next one moves on.
    assign w_adv3  = !r_v3 || i_ready;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_ready = w_adv1;
    assign o_valid = r_v3;
    assign o_div   = r_div;

    // Stage 1: trimap decode and the eight squares.
    always_comb begin
        if (i_pix.inner_mask) begin
            n_sq.region = REGION_FG;
        end else if (i_pix.outer_mask) begin
            n_sq.region = REGION_UNKNOWN;
        end else begin
            n_sq.region = REGION_BG;
        end
        n_sq.sq_sgx   = sq16(i_pix.src_grad_x);
        n_sq.sq_sgy   = sq16(i_pix.src_grad_y);
        n_sq.sq_tgx   = sq16(i_pix.tgt_grad_x);
        n_sq.sq_tgy   = sq16(i_pix.tgt_grad_y);
        n_sq.sq_sfx   = sq16(i_pix.src_flow_x);
        n_sq.sq_sfy   = sq16(i_pix.src_flow_y);
        n_sq.sq_tfx   = sq16(i_pix.tgt_flow_x);
        n_sq.sq_tfy   = sq16(i_pix.tgt_flow_y);
        n_sq.src_conf = i_pix.src_conf;
        n_sq.tgt_conf = i_pix.tgt_conf;
    end

    // Stage 2: magnitudes, gradient denominator and confidence test.
    always_comb begin
        logic [MAG_W-1:0] gt;
        n_mag.region  = r_sq.region;
        n_mag.gs      = MAG_W'(r_sq.sq_sgx) + MAG_W'(r_sq.sq_sgy);
        gt            = MAG_W'(r_sq.sq_tgx) + MAG_W'(r_sq.sq_tgy);
        n_mag.den     = DEN_W'(n_mag.gs) + DEN_W'(gt);
        n_mag.src_mag = MAG_W'(r_sq.sq_sfx) + MAG_W'(r_sq.sq_sfy);
        n_mag.tgt_mag = MAG_W'(r_sq.sq_tfx) + MAG_W'(r_sq.sq_tfy);
        n_mag.src_hi  = r_sq.src_conf > HALF_Q16;
        n_mag.tgt_hi  = r_sq.tgt_conf > HALF_Q16;
        n_mag.src_low = ONE_Q16 - r_sq.src_conf;
        n_mag.tgt_low = ONE_Q16 - r_sq.tgt_conf;
    end

    // Stage 3: load the dividers. A zero divisor acts as one, and a motion
    // quotient that would need more bits than the divider makes saturates.
    assign w_div = (i_motion_div == '0) ? MDIV_W'(1) : i_motion_div;

    always_comb begin
        n_div.region   = r_mag.region;
        n_div.den_zero = r_mag.den == '0;
        n_div.den_sh   = {r_mag.den, (QBITS-1)'(0)};
        n_div.rat_rem  = {r_mag.gs, 16'd0};
        n_div.rat_q    = '0;
        n_div.mdiv_sh  = {w_div, (QBITS-1)'(0)};
        n_div.src_hi   = r_mag.src_hi;
        n_div.src_sat  = (MSH_W+1)'(r_mag.src_mag) >= {w_div, QBITS'(0)};
        n_div.src_low  = r_mag.src_low;
        n_div.src_rem  = r_mag.src_mag;
        n_div.src_q    = '0;
        n_div.tgt_hi   = r_mag.tgt_hi;
        n_div.tgt_sat  = (MSH_W+1)'(r_mag.tgt_mag) >= {w_div, QBITS'(0)};
        n_div.tgt_low  = r_mag.tgt_low;
        n_div.tgt_rem  = r_mag.tgt_mag;
        n_div.tgt_q    = '0;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
            if (w_adv3) r_v3 <= r_v2;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_adv1) r_sq  <= n_sq;
        if (w_adv2) r_mag <= n_mag;
        if (w_adv3) r_div <= n_div;
    end

endmodule

/* hdl/maap_div_step.sv */
// One restoring division step for the gradient ratio and both motion terms.
// Depends on maap_pkg.
module maap_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  maap_pkg::t_div i_div,
    output logic           o_valid,
    input  logic           i_ready,
    output maap_pkg::t_div o_div
);
    import maap_pkg::*;

    logic r_v;
    logic w_adv;
    t_div r_div, n_div;

    assign w_adv   = !r_v || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v;
    assign o_div   = r_div;

    // Subtract the shifted divisor where it fits and shift in a quotient bit.
    always_comb begin
        logic ge_r, ge_s, ge_t;
        n_div = i_div;
        ge_r  = DSH_W'(i_div.rat_rem) >= i_div.den_sh;
        ge_s  = MSH_W'(i_div.src_rem) >= i_div.mdiv_sh;
        ge_t  = MSH_W'(i_div.tgt_rem) >= i_div.mdiv_sh;
        if (ge_r) begin
            n_div.rat_rem = i_div.rat_rem - i_div.den_sh[RR_W-1:0];
        end
        if (ge_s) begin
            n_div.src_rem = i_div.src_rem - i_div.mdiv_sh[MAG_W-1:0];
        end
        if (ge_t) begin
            n_div.tgt_rem = i_div.tgt_rem - i_div.mdiv_sh[MAG_W-1:0];
        end
        n_div.rat_q   = {i_div.rat_q[QBITS-2:0], ge_r};
        n_div.src_q   = {i_div.src_q[QBITS-2:0], ge_s};
        n_div.tgt_q   = {i_div.tgt_q[QBITS-2:0], ge_t};
        n_div.den_sh  = i_div.den_sh >> 1;
        n_div.mdiv_sh = i_div.mdiv_sh >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_adv) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_div <= n_div;
    end

endmodule

/* hdl/maap_blend.sv */
// Back end of the kernel: weighting of the motion terms, sum, clamp and region override.
// Depends on maap_pkg.
module maap_blend (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  maap_pkg::t_div i_div,
    input  logic [15:0]    i_src_weight,
    input  logic [15:0]    i_tgt_weight,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [16:0]    o_alpha,
    output logic [1:0]     o_region
);
    import maap_pkg::*;

    logic        r_v1, r_v2;
    logic        w_adv1, w_adv2;
    t_prod       r_prod, n_prod;
    logic [16:0] r_alpha, n_alpha;
    logic [1:0]  r_region;

    // Motion term: clamped flow quotient when confident, else one minus confidence.
    function automatic logic [QBITS-1:0] motion(input logic hi, input logic sat,
                                                input logic [QBITS-1:0] q,
                                                input logic [16:0] low);
        logic [QBITS-1:0] d;
        if (!hi) begin
            d = QBITS'(low);
        end else if (sat || q > D_SAT) begin
            d = D_SAT;
        end else begin
            d = q;
        end
        return d;
    endfunction

    assign w_adv2   = !r_v2 || i_ready;
    assign w_adv1   = !r_v1 || w_adv2;
    assign o_ready  = w_adv1;
    assign o_valid  = r_v2;
    assign o_alpha  = r_alpha;
    assign o_region = r_region;

    // Stage 1: ratio select and the two weight products.
    always_comb begin
        logic [QBITS-1:0] ds, dt;
        ds              = motion(i_div.src_hi, i_div.src_sat, i_div.src_q, i_div.src_low);
        dt              = motion(i_div.tgt_hi, i_div.tgt_sat, i_div.tgt_q, i_div.tgt_low);
        n_prod.region   = i_div.region;
        n_prod.ratio    = i_div.den_zero ? 17'd0 : i_div.rat_q[16:0];
        n_prod.src_prod = PROD_W'(i_src_weight) * PROD_W'(ds);
        n_prod.tgt_prod = PROD_W'(i_tgt_weight) * PROD_W'(dt);
    end

    // Stage 2: signed sum in Q.24, clamp to [0, 1], trimap override.
    always_comb begin
        logic signed [ACC_W-1:0] acc;
        logic        [ACC_W-1:0] clamped;
        acc = $signed(ACC_W'({r_prod.ratio, 8'd0}))
            + $signed(ACC_W'(r_prod.src_prod))
            - $signed(ACC_W'(r_prod.tgt_prod));
        if (acc < 0) begin
            clamped = '0;
        end else if (acc > $signed(ONE_Q24)) begin
            clamped = ONE_Q24;
        end else begin
            clamped = acc;
        end
        case (r_prod.region)
            REGION_BG:      n_alpha = 17'd0;
            REGION_UNKNOWN: n_alpha = clamped[24:8];
            default:        n_alpha = ONE_Q16;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_adv1) r_v1 <= i_valid;
            if (w_adv2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) r_prod <= n_prod;
        if (w_adv2) begin
            r_alpha  <= n_alpha;
            r_region <= r_prod.region;
        end
    end

endmodule
